// ===== hdl/alpha_blend_pixel_store_assert.svh =====
// Assertion macros shared by the pixel store RTL.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef ALPHA_BLEND_PIXEL_STORE_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_STORE_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ABPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("abps: assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ABPS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("abps: forbidden condition seen");
`else
`define ABPS_ASSERT(lbl, clk, rstn, prop)
`define ABPS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hdl/abps_pkg.sv =====
// Shared constants, types and the divide-by-255 helper of the pixel store.
// Used by every module of the block but abps_ram; depends on nothing.
`default_nettype none

package abps_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam int DimW   = 9;
  localparam int CoordW = 16;
  localparam int ChanW  = 8;
  localparam int PixW   = 4 * ChanW;
  localparam int CfgIdxW = 2;

  localparam int QueueDepth = 2;

  localparam logic [ChanW-1:0] ChanMax    = 8'hFF;
  localparam logic [PixW-1:0]  WhitePixel = 32'hFFFF_FFFF;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  // One classified pixel write on its way to the blend unit
  typedef struct packed {
    logic             in_bounds;
    logic             copy_src;
    logic [AddrW-1:0] addr;
    logic [ChanW-1:0] a;
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } abps_item_t;

  typedef struct packed {
    logic clearing;
  } abps_back_stat_t;

  // Exact floor(s / 255) for s up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] s);
    logic [2*ChanW:0] t;
    t = {1'b0, s} + {{(ChanW+1){1'b0}}, s[2*ChanW-1:ChanW]} + {{(2*ChanW){1'b0}}, 1'b1};
    return t[2*ChanW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/abps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module abps_ram #(
  parameter int DataW = 32,
  parameter int Depth = 256
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [DataW-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [DataW-1:0]                         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/abps_front.sv =====
// Front end: size registers, bounds check, address and copy/blend decision.
// Depends on abps_pkg; feeds abps_queue.
`default_nettype none

module abps_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [abps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [abps_pkg::DimW-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [abps_pkg::CoordW-1:0]  x_pos_i,
  input  wire logic signed [abps_pkg::CoordW-1:0]  y_pos_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_alpha_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_red_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_green_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_blue_i,
  input  wire abps_pkg::abps_back_stat_t           back_stat_i,
  output logic                                     push_o,
  input  wire logic                                push_ready_i,
  output abps_pkg::abps_item_t                     item_o
);
  import abps_pkg::*;

  logic [DimW-1:0]     width_q, width_d;
  logic [DimW-1:0]     height_q, height_d;
  logic [CoordW-1:0]   xu, yu;
  logic [2*DimW-1:0]   row_base;
  logic [2*DimW:0]     lin_addr;
  logic                in_bounds;

  // Config writes are always taken; sizes saturate to the store geometry
  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth: begin
          width_d = ({23'd0, cfg_wdata_i} > 32'(MaxWidth)) ? DimW'(MaxWidth) : cfg_wdata_i;
        end
        RegImageHeight: begin
          height_d = ({23'd0, cfg_wdata_i} > 32'(MaxHeight)) ? DimW'(MaxHeight) : cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= (32'd256 > 32'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(256);
      height_q <= (32'd256 > 32'(MaxHeight)) ? DimW'(MaxHeight) : DimW'(256);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign xu = x_pos_i;
  assign yu = y_pos_i;

  // Sign bit set means a negative coordinate
  assign in_bounds = !xu[CoordW-1] && !yu[CoordW-1] &&
                     (xu < {{(CoordW-DimW){1'b0}}, width_q}) &&
                     (yu < {{(CoordW-DimW){1'b0}}, height_q});

  // y is below the height here, so its low bits carry the whole row number
  assign row_base = {{DimW{1'b0}}, yu[DimW-1:0]} * {{DimW{1'b0}}, width_q};
  assign lin_addr = {{(DimW+1){1'b0}}, xu[DimW-1:0]} + {1'b0, row_base};

  assign in_stall_o = !push_ready_i || back_stat_i.clearing;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    item_o.in_bounds = in_bounds;
    item_o.copy_src  = (src_alpha_i == ChanMax) ||
                       ({src_alpha_i, src_red_i, src_green_i, src_blue_i} == '0);
    item_o.addr      = AddrW'(lin_addr);
    item_o.a         = src_alpha_i;
    item_o.r         = src_red_i;
    item_o.g         = src_green_i;
    item_o.b         = src_blue_i;
  end

endmodule

`default_nettype wire

// ===== hdl/abps_queue.sv =====
// Short FIFO of classified pixel writes between front and back.
// Depends on abps_pkg for the item type and depth.
`default_nettype none
`include "alpha_blend_pixel_store_assert.svh"

module abps_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       push_ready_o,
  input  wire abps_pkg::abps_item_t  push_item_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_i,
  output abps_pkg::abps_item_t       pop_item_o
);
  import abps_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  abps_item_t      slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ABPS_NEVER(a_q_no_overflow, clk_i, rst_ni, push_i && !push_ready_o)
  `ABPS_NEVER(a_q_no_underflow, clk_i, rst_ni, pop_i && !pop_valid_o)

endmodule

`default_nettype wire

// ===== hdl/abps_back.sv =====
// Back end: clearing sweep, read-modify-write of the pixel RAM, result register.
// Depends on abps_pkg and abps_ram; drains abps_queue.
`default_nettype none
`include "alpha_blend_pixel_store_assert.svh"

module abps_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire abps_pkg::abps_item_t          q_item_i,
  output abps_pkg::abps_back_stat_t          stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               written_o,
  output logic [abps_pkg::ChanW-1:0]         out_alpha_o,
  output logic [abps_pkg::ChanW-1:0]         out_red_o,
  output logic [abps_pkg::ChanW-1:0]         out_green_o,
  output logic [abps_pkg::ChanW-1:0]         out_blue_o
);
  import abps_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StMul   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreDepth - 1);

  logic [1:0]         state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  abps_item_t         cur_q;
  logic [2*ChanW-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [2*ChanW-1:0] sum_r_d, sum_g_d, sum_b_d;
  logic [ChanW-1:0]   inv_a;
  logic               out_valid_q;
  logic               written_q;
  logic [PixW-1:0]    out_pix_q;
  logic [PixW-1:0]    new_pix;
  logic               load;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr;
  logic [PixW-1:0]    ram_wdata, ram_rdata;

  abps_ram #(
    .DataW (PixW),
    .Depth (StoreDepth)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_item_i.addr),
    .rdata_o (ram_rdata)
  );

  // old*(255-a) + new*a per colour channel
  assign inv_a   = ChanMax - cur_q.a;
  assign sum_r_d = ({{ChanW{1'b0}}, ram_rdata[3*ChanW-1:2*ChanW]} * {{ChanW{1'b0}}, inv_a}) +
                   ({{ChanW{1'b0}}, cur_q.r} * {{ChanW{1'b0}}, cur_q.a});
  assign sum_g_d = ({{ChanW{1'b0}}, ram_rdata[2*ChanW-1:ChanW]} * {{ChanW{1'b0}}, inv_a}) +
                   ({{ChanW{1'b0}}, cur_q.g} * {{ChanW{1'b0}}, cur_q.a});
  assign sum_b_d = ({{ChanW{1'b0}}, ram_rdata[ChanW-1:0]} * {{ChanW{1'b0}}, inv_a}) +
                   ({{ChanW{1'b0}}, cur_q.b} * {{ChanW{1'b0}}, cur_q.a});

  assign new_pix = cur_q.copy_src ? {cur_q.a, cur_q.r, cur_q.g, cur_q.b}
                                  : {ChanMax, div255(sum_r_q), div255(sum_g_q),
                                     div255(sum_b_q)};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    q_pop_o   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_q.addr;
    ram_wdata = new_pix;
    load      = 1'b0;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = WhitePixel;
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_re  = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StFin;
      end
      StFin: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          ram_we  = cur_q.in_bounds;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (state_q == StMul) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
    end
    if (load) begin
      written_q <= cur_q.in_bounds;
      out_pix_q <= cur_q.in_bounds ? new_pix : '0;
    end
  end

  assign stat_o.clearing = (state_q == StClear);

  assign out_valid_o = out_valid_q;
  assign written_o   = written_q;
  assign out_alpha_o = out_pix_q[4*ChanW-1:3*ChanW];
  assign out_red_o   = out_pix_q[3*ChanW-1:2*ChanW];
  assign out_green_o = out_pix_q[2*ChanW-1:ChanW];
  assign out_blue_o  = out_pix_q[ChanW-1:0];

  `ABPS_NEVER(a_no_result_overwrite, clk_i, rst_ni, load && out_valid_q && out_stall_i)
  `ABPS_ASSERT(a_pixel_write_has_result, clk_i, rst_ni,
               (ram_we && state_q != StClear) |-> (load && cur_q.in_bounds))
  `ABPS_ASSERT(a_pop_not_loaded_next, clk_i, rst_ni, q_pop_o |=> !load)
  `ABPS_NEVER(a_no_pop_while_clearing, clk_i, rst_ni, q_pop_o && stat_o.clearing)

endmodule

`default_nettype wire

// ===== hdl/alpha_blend_pixel_store.sv =====
// Top level of the ARGB pixel store with source-over blending.
// Depends on abps_pkg, abps_front, abps_queue, abps_back (and abps_ram below it).
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------------
//   in       | in_valid_i / in_stall_o  | x_pos_i, y_pos_i, src_alpha/red/green/blue_i
//   out      | out_valid_o / out_stall_i| written_o, out_alpha/red/green/blue_o
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// Each pixel passes through the blend unit in order: RAM read, multiply-add, divide and write back.
// That read-modify-write on the pixel RAM sets the rate, as the back pops no new pixel until the
// last is through write back; a 2-beat queue lets the front accept while the back works.
// After reset the store is swept to opaque white, one entry a cycle, all 65536 entries
// with in_stall_o high. Config writes are taken at any time.
// The result register holds a beat while out_stall_i is high.
`default_nettype none

module alpha_blend_pixel_store (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [abps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [abps_pkg::DimW-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [abps_pkg::CoordW-1:0]  x_pos_i,
  input  wire logic signed [abps_pkg::CoordW-1:0]  y_pos_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_alpha_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_red_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_green_i,
  input  wire logic [abps_pkg::ChanW-1:0]          src_blue_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     written_o,
  output logic [abps_pkg::ChanW-1:0]               out_alpha_o,
  output logic [abps_pkg::ChanW-1:0]               out_red_o,
  output logic [abps_pkg::ChanW-1:0]               out_green_o,
  output logic [abps_pkg::ChanW-1:0]               out_blue_o
);
  import abps_pkg::*;

  logic            push, push_ready;
  abps_item_t      push_item;
  logic            pop_valid, pop;
  abps_item_t      pop_item;
  abps_back_stat_t back_stat;

  abps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .src_alpha_i  (src_alpha_i),
    .src_red_i    (src_red_i),
    .src_green_i  (src_green_i),
    .src_blue_i   (src_blue_i),
    .back_stat_i  (back_stat),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  abps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  abps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_pop_o     (pop),
    .q_item_i    (pop_item),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .written_o   (written_o),
    .out_alpha_o (out_alpha_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

`default_nettype wire
